### rtl/lcg64_pkg.sv
// shared types and constants for the tempered lcg random generator
`default_nettype none

package lcg64_pkg;

    localparam int SEED_W  = 64;
    localparam int WORD_W  = 32;
    localparam int CMD_W   = 3;
    localparam int IN_W    = 288;

    // default depth of the command queue between front and back
    localparam int LCG_QUEUE_DEPTH = 2;

    // command codes as they arrive on the stream
    localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DERIVE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DRAW32  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DRAW64  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BOUNDED = 3'd4;

    // decoded operation handed to the back end
    typedef enum logic [2:0] {
        OP_LOAD,
        OP_DERIVE,
        OP_DRAW32,
        OP_DRAW64,
        OP_BOUNDED,
        OP_NONE
    } op_t;

    // one queued request
    typedef struct packed {
        op_t               op;
        logic [SEED_W-1:0] opnd_a;
        logic [SEED_W-1:0] opnd_b;
        logic [SEED_W-1:0] opnd_c;
        logic [WORD_W-1:0] bound;
    } cmd_t;

endpackage

`default_nettype wire

### rtl/lcg64_front.sv
// front end: accepts requests, decodes the command and feeds the queue
`default_nettype none

module lcg64_front
    import lcg64_pkg::*;
(
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,
    input  wire logic [CMD_W-1:0]  s_tuser,
    input  wire logic              q_full,
    output logic                   q_push,
    output cmd_t                   q_entry
);

    op_t op;

    always_comb
    begin
        unique case (s_tuser)
            CMD_LOAD:    op = OP_LOAD;
            CMD_DERIVE:  op = OP_DERIVE;
            CMD_DRAW32:  op = OP_DRAW32;
            CMD_DRAW64:  op = OP_DRAW64;
            CMD_BOUNDED: op = OP_BOUNDED;
            default:     op = OP_NONE;
        endcase
    end

    always_comb
    begin
        q_entry.op     = op;
        // load carries its seed in the first operand slot
        q_entry.opnd_a = (op == OP_LOAD) ? s_tdata[63:0] : s_tdata[127:64];
        q_entry.opnd_b = s_tdata[191:128];
        q_entry.opnd_c = s_tdata[255:192];
        q_entry.bound  = s_tdata[287:256];
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

`default_nettype wire

### rtl/lcg64_queue.sv
// short request queue between front and back end
`default_nettype none

module lcg64_queue
    import lcg64_pkg::*;
#(
    parameter int DEPTH = LCG_QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_entry,
    output logic      full,
    input  wire logic pop,
    output cmd_t      head,
    output logic      not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/lcg64_back.sv
// back end: seed state, shared multiplier sequencer, tempering, divider, output register
`default_nettype none

module lcg64_back
    import lcg64_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic [SEED_W-1:0] cfg_data,
    input  wire logic              q_valid,
    input  wire cmd_t              q_head,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [SEED_W-1:0]      m_tdata,
    output logic                   m_terr
);

    localparam logic [SEED_W-1:0] LCG_MUL  = 64'd6364136223846793005;
    localparam logic [SEED_W-1:0] LCG_INC  = 64'd1;
    localparam logic [WORD_W-1:0] PRIME_X  = 32'd2521008887;
    localparam logic [WORD_W-1:0] PRIME_Y  = 32'd20996011;
    localparam logic [WORD_W-1:0] PRIME_Z  = 32'd3010349;
    localparam logic [WORD_W-1:0] TEMPER_B = 32'h9D2C5680;
    localparam logic [WORD_W-1:0] TEMPER_C = 32'hEFC60000;
    localparam logic [2:0] LAST_DRAW   = 3'd2;
    localparam logic [2:0] LAST_DERIVE = 3'd5;
    localparam logic [4:0] DIV_LAST    = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FLUSH,
        ST_SEED,
        ST_DIV,
        ST_OUT
    } state_t;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [SEED_W-1:0]  opa_reg, opa_next;
    logic [SEED_W-1:0]  opb_reg, opb_next;
    logic [SEED_W-1:0]  opc_reg, opc_next;
    logic [WORD_W-1:0]  bound_reg, bound_next;
    logic [SEED_W-1:0]  seed_reg, seed_next;
    logic [SEED_W-1:0]  base_reg, base_next;
    logic [SEED_W-1:0]  acc_reg, acc_next;
    logic [2:0]         step_reg, step_next;
    logic [SEED_W-1:0]  prod_reg, prod_next;
    logic               prod_hi_reg, prod_hi_next;
    logic               prod_vld_reg, prod_vld_next;
    logic               half_reg, half_next;
    logic [SEED_W-1:0]  res_reg, res_next;
    logic               err_reg, err_next;
    logic [WORD_W-1:0]  rem_reg, rem_next;
    logic [WORD_W-1:0]  dvd_reg, dvd_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [SEED_W-1:0]  out_data_reg, out_data_next;
    logic               out_err_reg, out_err_next;

    logic [WORD_W-1:0]  mul_a, mul_b;
    logic               mul_hi;
    logic [SEED_W-1:0]  coord;
    logic [WORD_W-1:0]  prime;
    logic [SEED_W-1:0]  addend;
    logic [WORD_W-1:0]  word;
    logic [WORD_W:0]    rem_sh, rem_diff;
    logic [2:0]         step_last;

    // operand selection for the shared 32x32 multiplier
    always_comb
    begin
        case (step_reg[2:1])
            2'd0:    begin coord = opa_reg; prime = PRIME_X; end
            2'd1:    begin coord = opb_reg; prime = PRIME_Y; end
            default: begin coord = opc_reg; prime = PRIME_Z; end
        endcase
        if (op_reg == OP_DERIVE)
        begin
            // coordinate times prime: low half full, high half only its low word
            mul_hi = step_reg[0];
            mul_a  = step_reg[0] ? coord[63:32] : coord[31:0];
            mul_b  = prime;
        end
        else
        begin
            // seed times multiplier mod 2^64: lo*lo, lo*hi, hi*lo
            case (step_reg)
                3'd0:    begin mul_a = seed_reg[31:0];  mul_b = LCG_MUL[31:0];  mul_hi = 1'b0; end
                3'd1:    begin mul_a = seed_reg[31:0];  mul_b = LCG_MUL[63:32]; mul_hi = 1'b1; end
                default: begin mul_a = seed_reg[63:32]; mul_b = LCG_MUL[31:0];  mul_hi = 1'b1; end
            endcase
        end
    end

    assign step_last = (op_reg == OP_DERIVE) ? LAST_DERIVE : LAST_DRAW;
    assign addend    = prod_hi_reg ? {prod_reg[31:0], 32'd0} : prod_reg;
    assign word      = temper(acc_reg[63:32]);
    assign rem_sh    = {rem_reg, dvd_reg[WORD_W-1]};
    assign rem_diff  = rem_sh - {1'b0, bound_reg};
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        opc_next       = opc_reg;
        bound_next     = bound_reg;
        seed_next      = seed_reg;
        base_next      = cfg_valid ? cfg_data : base_reg;
        acc_next       = prod_vld_reg ? acc_reg + addend : acc_reg;
        step_next      = step_reg;
        prod_next      = {32'd0, mul_a} * {32'd0, mul_b};
        prod_hi_next   = mul_hi;
        prod_vld_next  = (state_reg == ST_MUL);
        half_next      = half_reg;
        res_next       = res_reg;
        err_next       = err_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        cnt_next       = cnt_reg;
        out_valid_next = (out_valid_reg && m_tready) ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        out_err_next   = out_err_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    op_next    = q_head.op;
                    opa_next   = q_head.opnd_a;
                    opb_next   = q_head.opnd_b;
                    opc_next   = q_head.opnd_c;
                    bound_next = q_head.bound;
                    step_next  = '0;
                    half_next  = 1'b0;
                    err_next   = 1'b0;
                    res_next   = '0;
                    unique case (q_head.op)
                        OP_LOAD:
                        begin
                            seed_next  = q_head.opnd_a;
                            res_next   = q_head.opnd_a;
                            state_next = ST_OUT;
                        end
                        OP_DERIVE:
                        begin
                            acc_next   = base_reg;
                            state_next = ST_MUL;
                        end
                        OP_DRAW32, OP_DRAW64, OP_BOUNDED:
                        begin
                            acc_next   = LCG_INC;
                            state_next = ST_MUL;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == step_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // last partial product lands in the accumulator here
                state_next = ST_SEED;
            end
            ST_SEED:
            begin
                seed_next = acc_reg;
                case (op_reg)
                    OP_DERIVE:
                    begin
                        res_next   = acc_reg;
                        state_next = ST_OUT;
                    end
                    OP_DRAW64:
                    begin
                        if (!half_reg)
                        begin
                            res_next[31:0] = word;
                            half_next      = 1'b1;
                            acc_next       = LCG_INC;
                            step_next      = '0;
                            state_next     = ST_MUL;
                        end
                        else
                        begin
                            res_next[63:32] = word;
                            state_next      = ST_OUT;
                        end
                    end
                    OP_BOUNDED:
                    begin
                        if (bound_reg == '0)
                        begin
                            res_next   = '0;
                            err_next   = 1'b1;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            rem_next   = '0;
                            dvd_next   = word;
                            cnt_next   = '0;
                            state_next = ST_DIV;
                        end
                    end
                    default:
                    begin
                        res_next   = {32'd0, word};
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_DIV:
            begin
                // restoring remainder, one dividend bit per cycle
                rem_next = rem_diff[WORD_W] ? rem_sh[WORD_W-1:0] : rem_diff[WORD_W-1:0];
                dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    res_next   = {32'd0, rem_next};
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    out_err_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_NONE;
            opa_reg       <= '0;
            opb_reg       <= '0;
            opc_reg       <= '0;
            bound_reg     <= '0;
            seed_reg      <= '0;
            base_reg      <= '0;
            acc_reg       <= '0;
            step_reg      <= '0;
            prod_reg      <= '0;
            prod_hi_reg   <= 1'b0;
            prod_vld_reg  <= 1'b0;
            half_reg      <= 1'b0;
            res_reg       <= '0;
            err_reg       <= 1'b0;
            rem_reg       <= '0;
            dvd_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            opa_reg       <= opa_next;
            opb_reg       <= opb_next;
            opc_reg       <= opc_next;
            bound_reg     <= bound_next;
            seed_reg      <= seed_next;
            base_reg      <= base_next;
            acc_reg       <= acc_next;
            step_reg      <= step_next;
            prod_reg      <= prod_next;
            prod_hi_reg   <= prod_hi_next;
            prod_vld_reg  <= prod_vld_next;
            half_reg      <= half_next;
            res_reg       <= res_next;
            err_reg       <= err_next;
            rem_reg       <= rem_next;
            dvd_reg       <= dvd_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_err_reg   <= out_err_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_terr   = out_err_reg;

endmodule

`default_nettype wire

### rtl/lcg64_tempered_random_generator.sv
// top level of the 64-bit lcg random generator with tempered output
// the back end takes one request at a time and finishes it before popping the next;
// derive and the draws use the shared 32x32 multiplier, bounded draw also the divider
// the queue takes new requests while the back end works or a result waits, until it is full
// async active-low reset clears seed, base seed, queue and output valid
`default_nettype none

module lcg64_tempered_random_generator
    import lcg64_pkg::*;
#(
    parameter int QUEUE_DEPTH = LCG_QUEUE_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,   // seed_value, chunk_x, chunk_y, chunk_z, bound
    input  wire logic [CMD_W-1:0]  s_tuser,   // command
    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [SEED_W-1:0]      m_tdata,   // value
    output logic [0:0]             m_tuser,   // divide_error
    // base seed write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [SEED_W-1:0] cfg_data
);

    // front to queue
    logic q_push;
    logic q_full;
    cmd_t q_entry;

    // queue to back
    logic q_valid;
    logic q_pop;
    cmd_t q_head;

    logic m_err;

    // base seed is always writable
    assign cfg_ready = 1'b1;

    // decode the command and push into the queue
    lcg64_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    // short queue so the front keeps taking requests while the back is busy
    lcg64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .not_empty  (q_valid)
    );

    // seed update, tempering, remainder and the output register
    lcg64_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_terr    (m_err)
    );

    assign m_tuser = m_err;

    // a zero-bound error always comes with a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("divide error with nonzero value");

    // a full queue is never empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_valid)
        else $error("request stalled with empty queue");

    // back end only pops a queue entry that is there
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // the queue fills only through an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(q_push))
        else $error("queue filled without a push");

endmodule

`default_nettype wire

### test/lcg64_tempered_random_generator_test.sv
// self-checking testbench for the tempered 64-bit lcg random generator
`timescale 1ns / 100ps

module lcg64_tempered_random_generator_test
    import lcg64_pkg::*;
();

    // lcg and seed mix constants
    localparam logic [63:0] LCG_MULT = 64'd6364136223846793005;
    localparam logic [63:0] LCG_INCR = 64'd1;
    localparam logic [63:0] PRIME_X  = 64'd2521008887;
    localparam logic [63:0] PRIME_Y  = 64'd20996011;
    localparam logic [63:0] PRIME_Z  = 64'd3010349;
    localparam logic [31:0] TEMPER_B = 32'h9D2C5680;
    localparam logic [31:0] TEMPER_C = 32'hEFC60000;

    // command codes with no operation behind them
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

    localparam logic [63:0] ONES64   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN64    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          CLK_HALF = 2;
    localparam int          CYCLE_LIMIT    = 800_000;
    localparam int          ITEMS_PER_PHASE = 350;
    localparam int          RANDOM_PHASES   = 5;

    // one request as it travels on the stream
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [63:0]      seed_value;
        logic [63:0]      chunk_x;
        logic [63:0]      chunk_y;
        logic [63:0]      chunk_z;
        logic [31:0]      bound;
    } request_t;

    // one result: generated value and divide error flag
    typedef struct packed {
        logic [63:0] value;
        logic        divide_error;
    } outcome_t;

    // directed row; outcome is only used where known is set
    typedef struct packed {
        request_t req;
        logic     known;
        outcome_t outcome;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 22;

    localparam directed_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
        // seed is zero after reset, so the first draw gives a zero word
        '{'{CMD_DRAW32, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0}, 1'b1, '{64'd0, 1'b0}},
        // zero bound still advances the seed and raises the flag
        '{'{CMD_BOUNDED, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0}, 1'b1, '{64'd0, 1'b1}},
        '{'{CMD_LOAD, 64'd0, ONES64, ONES64, ONES64, 32'hFFFF_FFFF}, 1'b1, '{64'd0, 1'b0}},
        '{'{CMD_LOAD, ONES64, ONES64, ONES64, ONES64, 32'hFFFF_FFFF}, 1'b1, '{ONES64, 1'b0}},
        '{'{CMD_DRAW32, ONES64, ONES64, ONES64, ONES64, 32'hFFFF_FFFF}, 1'b0, '0},
        '{'{CMD_DRAW64, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0}, 1'b0, '0},
        // any word modulo one is zero
        '{'{CMD_BOUNDED, ONES64, ONES64, ONES64, ONES64, 32'd1}, 1'b1, '{64'd0, 1'b0}},
        '{'{CMD_BOUNDED, 64'd0, 64'd0, 64'd0, 64'd0, 32'hFFFF_FFFF}, 1'b0, '0},
        '{'{CMD_BOUNDED, 64'd0, 64'd0, 64'd0, 64'd0, 32'h8000_0000}, 1'b0, '0},
        '{'{CMD_BOUNDED, 64'd0, 64'd0, 64'd0, 64'd0, 32'd7}, 1'b0, '0},
        // spare commands leave the seed alone and return zeros
        '{'{CMD_SPARE_A, ONES64, ONES64, ONES64, ONES64, 32'd0}, 1'b1, '{64'd0, 1'b0}},
        '{'{CMD_SPARE_B, ONES64, ONES64, ONES64, ONES64, 32'd0}, 1'b1, '{64'd0, 1'b0}},
        '{'{CMD_SPARE_C, ONES64, ONES64, ONES64, ONES64, 32'd0}, 1'b1, '{64'd0, 1'b0}},
        '{'{CMD_DRAW32, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0}, 1'b0, '0},
        // base seed is zero in this phase, so origin coordinates give zero
        '{'{CMD_DERIVE, ONES64, 64'd0, 64'd0, 64'd0, 32'hFFFF_FFFF}, 1'b1, '{64'd0, 1'b0}},
        '{'{CMD_DERIVE, 64'd0, MAX64, MIN64, ONES64, 32'd0}, 1'b0, '0},
        '{'{CMD_DERIVE, 64'd0, ONES64, ONES64, ONES64, 32'd0}, 1'b0, '0},
        '{'{CMD_DERIVE, 64'd0, MIN64, MAX64, 64'd1, 32'd0}, 1'b0, '0},
        '{'{CMD_DRAW64, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0}, 1'b0, '0},
        '{'{CMD_LOAD, MIN64, 64'd0, 64'd0, 64'd0, 32'd0}, 1'b1, '{MIN64, 1'b0}},
        '{'{CMD_BOUNDED, ONES64, 64'd0, 64'd0, 64'd0, 32'd0}, 1'b1, '{64'd0, 1'b1}},
        '{'{CMD_DRAW32, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0}, 1'b0, '0}
    };

    // dut connections; the inputs are known from time zero
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata   = '0;
    logic [CMD_W-1:0]    s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [SEED_W-1:0]   m_tdata;
    logic [0:0]          m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [SEED_W-1:0]   cfg_data  = '0;

    // predictor state: generator seed and the base seed it was last given
    logic [63:0] seed_model      = '0;
    logic [63:0] base_seed_model = '0;

    // results still owed by the block, newest at the front, oldest at the back
    outcome_t pending_outcomes[$];

    int error_count = 0;
    int cycle_count = 0;
    int burst_left  = 0;

    // receiver pattern state
    logic [15:0] ready_cycle = '0;
    logic [1:0]  ready_mode  = '0;

    lcg64_tempered_random_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // seed_value, chunk_x, chunk_y, chunk_z, bound
        .s_tuser   (s_tuser),    // command
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // value
        .m_tuser   (m_tuser),    // divide_error
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // generous run limit, reckoned from the slowest correct run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // mersenne twister output tempering, all at 32 bits
    function automatic logic [31:0] temper_word(input logic [31:0] y);
        y ^= y >> 11;
        y ^= (y << 7) & TEMPER_B;
        y ^= (y << 15) & TEMPER_C;
        y ^= y >> 18;
        return y;
    endfunction

    // one lcg step, returning the tempered high word of the new seed
    function automatic logic [31:0] advance_and_temper();
        seed_model = seed_model * LCG_MULT + LCG_INCR;
        return temper_word(seed_model[63:32]);
    endfunction

    // expected result of one accepted request, updating the seed model
    function automatic outcome_t predict_outcome(input request_t req);
        outcome_t    res;
        logic [31:0] lo_word;
        logic [31:0] hi_word;
        res = '0;
        case (req.cmd)
            CMD_LOAD:
            begin
                seed_model = req.seed_value;
                res.value  = seed_model;
            end
            CMD_DERIVE:
            begin
                // unsigned products give the same low 64 bits as signed ones
                seed_model = base_seed_model + req.chunk_x * PRIME_X
                             + req.chunk_y * PRIME_Y + req.chunk_z * PRIME_Z;
                res.value  = seed_model;
            end
            CMD_DRAW32:
                res.value = {32'd0, advance_and_temper()};
            CMD_DRAW64:
            begin
                // first draw lands in the low word
                lo_word   = advance_and_temper();
                hi_word   = advance_and_temper();
                res.value = {hi_word, lo_word};
            end
            CMD_BOUNDED:
            begin
                lo_word = advance_and_temper();
                if (req.bound == 32'd0)
                    res.divide_error = 1'b1;
                else
                    res.value = {32'd0, lo_word % req.bound};
            end
            default:
                res = '0;
        endcase
        return res;
    endfunction

    function automatic logic [63:0] random_word64();
        return {$urandom, $urandom};
    endfunction

    // chunk coordinate: small signed values, full-range values and edges
    function automatic logic [63:0] random_coord();
        logic [63:0] c;
        case ($urandom_range(0, 7))
            0:       c = MAX64;
            1:       c = MIN64;
            2:       c = ONES64;
            3, 4:    c = random_word64();
            default:
            begin
                c = 64'($urandom_range(0, 1000));
                if ($urandom_range(0, 1) == 1)
                    c = -c;
            end
        endcase
        return c;
    endfunction

    // random request; fields the command does not use carry noise
    function automatic request_t random_request();
        request_t req;
        int       pick;
        req.seed_value = random_word64();
        req.chunk_x    = random_coord();
        req.chunk_y    = random_coord();
        req.chunk_z    = random_coord();
        req.bound      = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            req.cmd = CMD_LOAD;
            if ($urandom_range(0, 9) == 0)
                req.seed_value = ($urandom_range(0, 1) == 1) ? ONES64 : 64'd0;
        end
        else if (pick < 20)
            req.cmd = CMD_DERIVE;
        else if (pick < 40)
            req.cmd = CMD_DRAW32;
        else if (pick < 58)
            req.cmd = CMD_DRAW64;
        else if (pick < 95)
        begin
            req.cmd = CMD_BOUNDED;
            case ($urandom_range(0, 15))
                0:          req.bound = 32'd0;
                1:          req.bound = 32'd1;
                2:          req.bound = 32'hFFFF_FFFF;
                3, 4, 5:    req.bound = $urandom_range(2, 16);
                6, 7, 8, 9: req.bound = $urandom_range(17, 65535);
                default:    req.bound = $urandom;
            endcase
        end
        else
            req.cmd = CMD_LOAD + 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
        return req;
    endfunction

    // present one request, with bursts and gaps, and record its result
    task automatic send_request(input request_t req, input logic known,
                                input outcome_t known_outcome);
        int idle_cycles;
        if (burst_left == 0)
        begin
            // long bursts now and then give stretches with no idling
            burst_left  = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 10);
            idle_cycles = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45)
                                                      : $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (idle_cycles) @(posedge clk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= req.cmd;
        s_tdata  <= {req.bound, req.chunk_z, req.chunk_y, req.chunk_x, req.seed_value};
        do
            @(posedge clk);
        while (!s_tready);
        if (known)
        begin
            void'(predict_outcome(req));
            pending_outcomes.push_front(known_outcome);
        end
        else
            pending_outcomes.push_front(predict_outcome(req));
    endtask

    // let the block go idle, then write the base seed
    task automatic write_base_seed(input logic [63:0] seed);
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid       <= 1'b0;
        base_seed_model  = seed;
        burst_left       = 0;
    endtask

    // receiver: on a free-running counter, picks ready patterns at random: always ready, random or periodic
    always @(posedge clk)
    begin
        ready_cycle <= ready_cycle + 16'd1;
        if (ready_cycle[7:0] == 8'd0)
            ready_mode <= 2'($urandom_range(0, 3));
        if (!rst_n)
            m_tready <= 1'b0;
        else
            case (ready_mode)
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
                2'd2:    m_tready <= (ready_cycle[2:0] < 3'd3);
                default: m_tready <= ready_cycle[4];
            endcase
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_result
        outcome_t oldest;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("unexpected result: value %h, divide_error %b", m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                oldest = pending_outcomes.pop_back();
                if (m_tdata !== oldest.value)
                begin
                    $error("value: expected %h, actual %h", oldest.value, m_tdata);
                    error_count++;
                end
                if (m_tuser[0] !== oldest.divide_error)
                begin
                    $error("divide_error: expected %b, actual %b",
                           oldest.divide_error, m_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // stimulus: directed table first, then random phases over several base seeds
    initial
    begin : stimulus
        logic [63:0] phase_seed;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_base_seed(64'd0);
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(DIRECTED_TABLE[i].req, DIRECTED_TABLE[i].known,
                         DIRECTED_TABLE[i].outcome);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       phase_seed = ONES64;
                2:       phase_seed = MIN64;
                4:       phase_seed = 64'd0;
                default: phase_seed = random_word64();
            endcase
            write_base_seed(phase_seed);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_request(random_request(), 1'b0, '0);
        end

        // drain, then allow for the slowest request before deciding
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
rtl/lcg64_pkg.sv
rtl/lcg64_front.sv
rtl/lcg64_queue.sv
rtl/lcg64_back.sv
rtl/lcg64_tempered_random_generator.sv
test/lcg64_tempered_random_generator_test.sv
